### hdl/poisson_binomial_majority_assert.svh
// Assertion helpers used by poisson_binomial_majority. Each expects clk and rst in scope.
`ifndef POISSON_BINOMIAL_MAJORITY_ASSERT_SVH
`define POISSON_BINOMIAL_MAJORITY_ASSERT_SVH

// Same-cycle implication.
`define PBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbm assertion failed");

// Next-cycle implication.
`define PBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbm assertion failed");

`endif

### hdl/pbm_pkg.sv
`timescale 1ns / 1ps
package pbm_pkg;

  localparam int unsigned PROB_W = 17;
  localparam int unsigned VAL_W = 33;
  localparam int unsigned PROD_W = PROB_W + VAL_W;
  localparam int unsigned SUM_W = VAL_W + 1;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned MAX_COINS_DEFAULT = 1024;
  // drain counter value on the last cycle before the final write lands
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  localparam logic [PROB_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [VAL_W-1:0] Q32_ONE = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } pbm_state_t;

  typedef struct packed {
    logic vld;
    logic wr;
    logic acc;
  } pbm_flags_t;

endpackage

### hdl/poisson_binomial_majority.sv
`timescale 1ns / 1ps
// Poisson binomial majority tail. Feed one coin per item (heads probability,
// Q1.16, values above one saturate); the item with last_coin set yields one
// result: P(heads >= floor((n+1)/2)) in Q1.32 saturated at one, the coin
// count n and a flag for coins dropped because the set already held
// MAX_COINS. The head count distribution sits in one synchronous memory of
// MAX_COINS+1 words and each coin sweeps it with one read-modify-write per
// cycle. An item with c coins already in the set passes through the idle
// step that takes it, a sweep reading c + 2 entries, a drain of the
// read/multiply/write pipeline and the finish step, and the input stalls
// until it is back in idle; a dropped coin sweeps all MAX_COINS + 1 entries
// unchanged. A last item whose result finds the output register still held
// waits in the finish step until it frees. A finished result waits in an
// output register, so the next set can start while it is being taken. No
// clearing pass is needed after reset: entries are only used once written
// in the current set.
module poisson_binomial_majority #(
  parameter int unsigned MAX_COINS = pbm_pkg::MAX_COINS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbm_pkg::PROB_W-1:0]       heads_probability,
  input  logic                             last_coin,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pbm_pkg::VAL_W-1:0]        tail_probability,
  output logic [pbm_pkg::CNT_OUT_W-1:0]    coins_counted,
  output logic                             capacity_exceeded
);

  localparam int unsigned CW = $clog2(MAX_COINS + 1);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_COINS);

  pbm_pkg::pbm_state_t state, state_next;

  logic [CW-1:0]                 coin_count;
  logic                          overflow_seen;
  logic [pbm_pkg::PROB_W-1:0]    cur_p;
  logic [pbm_pkg::PROB_W-1:0]    cur_q;
  logic                          cur_first;
  logic                          cur_upd;
  logic                          cur_last;
  logic [CW-1:0]                 end_addr;
  logic [CW-1:0]                 half_addr;
  logic [CW-1:0]                 rd_addr;
  logic [1:0]                    drain_cnt;
  pbm_pkg::pbm_flags_t           s1_flags;
  logic [CW-1:0]                 s1_addr;
  logic [CW-1:0]                 m1_addr;
  logic [CW-1:0]                 m2_addr;
  logic [pbm_pkg::VAL_W-1:0]     prev;
  logic [pbm_pkg::VAL_W-1:0]     acc;

  logic                          in_acc;
  logic                          out_load;
  logic                          rd_en;
  logic                          can_add;
  logic [pbm_pkg::PROB_W-1:0]    p_sat;
  logic [CW-1:0]                 n_new;
  logic [CW:0]                   half_calc;
  logic [pbm_pkg::VAL_W-1:0]     rd_data;
  logic [pbm_pkg::VAL_W-1:0]     b_val;
  pbm_pkg::pbm_flags_t           mix_out_flags;
  logic [pbm_pkg::VAL_W-1:0]     mix_result;
  logic                          wr_en;
  logic [pbm_pkg::SUM_W-1:0]     acc_sum;

  assign in_stall = (state != pbm_pkg::ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign p_sat = (heads_probability > pbm_pkg::Q16_ONE) ? pbm_pkg::Q16_ONE
                                                        : heads_probability;
  assign can_add = (coin_count < MAX_N);
  assign n_new = can_add ? (coin_count + CW'(1)) : MAX_N;
  assign half_calc = ({1'b0, n_new} + (CW+1)'(1)) >> 1;

  // first coin seeds entry 0 with one; the entry above the old count is empty
  always_comb begin
    if (cur_first && (s1_addr == '0)) begin
      b_val = pbm_pkg::Q32_ONE;
    end else if (cur_upd && (s1_addr == end_addr)) begin
      b_val = '0;
    end else begin
      b_val = rd_data;
    end
  end

  assign wr_en = mix_out_flags.vld && mix_out_flags.wr;
  assign acc_sum = {1'b0, acc} + {1'b0, mix_result};

  pbm_dist_mem #(
    .DEPTH (MAX_COINS + 1),
    .AW    (CW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (m2_addr),
    .wr_data (mix_result),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pbm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_flags  (s1_flags),
    .p         (cur_p),
    .q         (cur_q),
    .a         (prev),
    .b         (b_val),
    .out_flags (mix_out_flags),
    .result    (mix_result)
  );

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    out_load = 1'b0;
    case (state)
      pbm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = pbm_pkg::ST_SWEEP;
        end
      end
      pbm_pkg::ST_SWEEP: begin
        rd_en = 1'b1;
        if (rd_addr == end_addr) begin
          state_next = pbm_pkg::ST_DRAIN;
        end
      end
      pbm_pkg::ST_DRAIN: begin
        if (drain_cnt == pbm_pkg::DRAIN_LAST) begin
          state_next = pbm_pkg::ST_FINISH;
        end
      end
      pbm_pkg::ST_FINISH: begin
        if (!cur_last) begin
          state_next = pbm_pkg::ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = pbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // set bookkeeping and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count <= '0;
      overflow_seen <= 1'b0;
      s1_flags <= '0;
      drain_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        if (can_add) begin
          coin_count <= n_new;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (out_load) begin
        coin_count <= '0;
        overflow_seen <= 1'b0;
      end
      s1_flags.vld <= rd_en;
      s1_flags.wr <= rd_en && cur_upd;
      s1_flags.acc <= rd_en && cur_last && (rd_addr >= half_addr);
      if (state == pbm_pkg::ST_DRAIN) begin
        drain_cnt <= drain_cnt + 2'd1;
      end else begin
        drain_cnt <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-item payload and pipeline datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_p <= can_add ? p_sat : '0;
      cur_q <= can_add ? (pbm_pkg::Q16_ONE - p_sat) : pbm_pkg::Q16_ONE;
      cur_first <= (coin_count == '0);
      cur_upd <= can_add;
      cur_last <= last_coin;
      end_addr <= n_new;
      half_addr <= half_calc[CW-1:0];
      rd_addr <= '0;
      prev <= '0;
      acc <= '0;
    end else begin
      if (rd_en) begin
        rd_addr <= rd_addr + CW'(1);
      end
      if (s1_flags.vld) begin
        prev <= b_val;
      end
      if (mix_out_flags.vld && mix_out_flags.acc) begin
        acc <= (acc_sum > {1'b0, pbm_pkg::Q32_ONE}) ? pbm_pkg::Q32_ONE
                                                    : acc_sum[pbm_pkg::VAL_W-1:0];
      end
    end
    s1_addr <= rd_addr;
    m1_addr <= s1_addr;
    m2_addr <= m1_addr;
    if (out_load) begin
      tail_probability <= acc;
      coins_counted <= pbm_pkg::CNT_OUT_W'(end_addr);
      capacity_exceeded <= overflow_seen;
    end
  end

`include "poisson_binomial_majority_assert.svh"

  `PBM_ASSERT_NOW(a_sweep_in_range, state == pbm_pkg::ST_SWEEP, rd_addr <= end_addr)
  `PBM_ASSERT_NOW(a_count_bound, 1'b1, coin_count <= MAX_N)
  `PBM_ASSERT_NOW(a_acc_bound, state != pbm_pkg::ST_IDLE, acc <= pbm_pkg::Q32_ONE)
  `PBM_ASSERT_NOW(a_write_in_sweep, wr_en, state == pbm_pkg::ST_SWEEP || state == pbm_pkg::ST_DRAIN)
  `PBM_ASSERT_NOW(a_drained, state == pbm_pkg::ST_FINISH, !s1_flags.vld && !mix_out_flags.vld)
  `PBM_ASSERT_NEXT(a_load_shows, out_load, out_valid)

endmodule

### hdl/pbm_dist_mem.sv
`timescale 1ns / 1ps
module pbm_dist_mem #(
  parameter int unsigned DEPTH = pbm_pkg::MAX_COINS_DEFAULT + 1,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [pbm_pkg::VAL_W-1:0]    wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [pbm_pkg::VAL_W-1:0]    rd_data
);

  logic [pbm_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/pbm_mix.sv
`timescale 1ns / 1ps
// Two-stage mix: (p*a >> 16) + (q*b >> 16), each product truncated on its own.
module pbm_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  pbm_pkg::pbm_flags_t           in_flags,
  input  logic [pbm_pkg::PROB_W-1:0]    p,
  input  logic [pbm_pkg::PROB_W-1:0]    q,
  input  logic [pbm_pkg::VAL_W-1:0]     a,
  input  logic [pbm_pkg::VAL_W-1:0]     b,
  output pbm_pkg::pbm_flags_t           out_flags,
  output logic [pbm_pkg::VAL_W-1:0]     result
);

  logic [pbm_pkg::PROD_W-1:0] prod_a;
  logic [pbm_pkg::PROD_W-1:0] prod_b;
  logic [pbm_pkg::SUM_W-1:0]  part_a;
  logic [pbm_pkg::SUM_W-1:0]  part_b;
  logic [pbm_pkg::SUM_W-1:0]  sum;
  pbm_pkg::pbm_flags_t        mid_flags;

  assign prod_a = {{pbm_pkg::VAL_W{1'b0}}, p} * {{pbm_pkg::PROB_W{1'b0}}, a};
  assign prod_b = {{pbm_pkg::VAL_W{1'b0}}, q} * {{pbm_pkg::PROB_W{1'b0}}, b};
  assign sum = part_a + part_b;

  always_ff @(posedge clk) begin
    part_a <= prod_a[16 +: pbm_pkg::SUM_W];
    part_b <= prod_b[16 +: pbm_pkg::SUM_W];
    result <= sum[pbm_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_flags <= '0;
      out_flags <= '0;
    end else begin
      mid_flags <= in_flags;
      out_flags <= mid_flags;
    end
  end

endmodule
